// ===== rtl/core/sdspi_pkg.sv =====
// Shared types and constants of the SD card SPI command sender.
`timescale 1ns / 1ps

package sdspi_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned CmdW     = 6;
  localparam int unsigned ArgW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned PollW    = 4;
  localparam int unsigned PosW     = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [OpW-1:0] {
    OP_START = 2'd0,
    OP_XCHG  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DESEL    = 3'd1,
    PH_SELDUMMY = 3'd2,
    PH_WAITRDY  = 3'd3,
    PH_TODESEL  = 3'd4,
    PH_SEND     = 3'd5,
    PH_DISCARD  = 3'd6,
    PH_RESP     = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_READY_TIMEOUT = 1'd0,
    CFG_POLL_LIMIT    = 1'd1
  } cfg_idx_e;

  localparam logic [CmdW-1:0]     CMD_GO_IDLE      = 6'd0;
  localparam logic [CmdW-1:0]     CMD_SEND_IF_COND = 6'd8;
  localparam logic [CmdW-1:0]     CMD_STOP         = 6'd12;
  localparam logic [CmdW-1:0]     CMD_APP          = 6'd55;
  localparam logic [ByteW-1:0]    FILL_BYTE        = 8'hFF;
  localparam logic [1:0]          START_BITS       = 2'b01;
  localparam logic [ByteW-1:0]    CRC_CMD0         = 8'h95;
  localparam logic [ByteW-1:0]    CRC_CMD8         = 8'h87;
  localparam logic [ByteW-1:0]    CRC_OTHER        = 8'h01;
  localparam logic [ByteW-1:0]    RESP_IDLE_MAX    = 8'h01;
  localparam logic [TimeoutW-1:0] TIMEOUT_RST      = 16'd500;
  localparam logic [PollW-1:0]    POLL_RST         = 4'd10;

  localparam logic [PosW-1:0] POS_ARG0 = 3'd1;
  localparam logic [PosW-1:0] POS_ARG1 = 3'd2;
  localparam logic [PosW-1:0] POS_ARG2 = 3'd3;
  localparam logic [PosW-1:0] POS_ARG3 = 3'd4;
  localparam logic [PosW-1:0] POS_CRC  = 3'd5;
  localparam logic [PosW-1:0] POS_DONE = 3'd6;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [CmdW-1:0]  cmd_index;
    logic             app_command;
    logic [ArgW-1:0]  argument;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [TimeoutW-1:0] ready_timeout_ms;
    logic [PollW-1:0]    response_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [ByteW-1:0] tx_byte;
    logic             chip_select_low;
    logic [ByteW-1:0] response;
    logic             ready_timed_out;
  } res_t;

endpackage

// ===== rtl/core/sdspi_if.sv =====
// Valid/ready channels for command items and result items.
`timescale 1ns / 1ps

interface sdspi_cmd_if
  import sdspi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [CmdW-1:0]  cmd_index;
  logic             app_command;
  logic [ArgW-1:0]  argument;
  logic [ByteW-1:0] rx_byte;

  modport source (
    output valid, operation, cmd_index, app_command, argument, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, cmd_index, app_command, argument, rx_byte,
    output ready
  );
endinterface

interface sdspi_res_if
  import sdspi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ByteW-1:0] tx_byte;
  logic             chip_select_low;
  logic [ByteW-1:0] response;
  logic             ready_timed_out;

  modport source (
    output valid, kind, tx_byte, chip_select_low, response, ready_timed_out,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, chip_select_low, response, ready_timed_out,
    output ready
  );
endinterface

// ===== rtl/core/sdspi_engine.sv =====
// Command sequencer: state registers and single-pass next-state logic.
`timescale 1ns / 1ps

module sdspi_engine
  import sdspi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  acc_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  phase_e              phase_q, phase_d;
  logic [CmdW-1:0]     cmd_q, cmd_d;
  logic                app_q, app_d;
  logic [ArgW-1:0]     arg_q, arg_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [TimeoutW-1:0] rdy_cnt_q, rdy_cnt_d;
  logic [PollW-1:0]    poll_cnt_q, poll_cnt_d;
  logic                sel_q, sel_d;

  logic [CmdW-1:0]  eff_cmd;
  logic [ArgW-1:0]  eff_arg;
  logic [CmdW-1:0]  begin_cmd;
  logic             do_begin;
  logic             do_poll;
  logic [PollW-1:0] poll_left;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cmd_q      <= '0;
      app_q      <= 1'b0;
      arg_q      <= '0;
      pos_q      <= '0;
      rdy_cnt_q  <= '0;
      poll_cnt_q <= '0;
      sel_q      <= 1'b0;
    end else if (acc_i) begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      app_q      <= app_d;
      arg_q      <= arg_d;
      pos_q      <= pos_d;
      rdy_cnt_q  <= rdy_cnt_d;
      poll_cnt_q <= poll_cnt_d;
      sel_q      <= sel_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    app_d      = app_q;
    arg_d      = arg_q;
    pos_d      = pos_q;
    rdy_cnt_d  = rdy_cnt_q;
    poll_cnt_d = poll_cnt_q;
    sel_d      = sel_q;
    res        = '0;
    do_begin   = 1'b0;
    do_poll    = 1'b0;
    begin_cmd  = cmd_q;
    poll_left  = '0;
    // the leading CMD55 always goes out with a zero argument
    eff_cmd    = app_q ? CMD_APP : cmd_q;
    eff_arg    = app_q ? '0 : arg_q;

    if (acc_i) begin
      case (op_e'(item_i.operation))
        OP_TICK: begin
          if (rdy_cnt_q != '0) begin
            rdy_cnt_d = rdy_cnt_q - 1'b1;
          end
        end
        OP_START: begin
          cmd_d     = item_i.cmd_index;
          app_d     = item_i.app_command;
          arg_d     = item_i.argument;
          pos_d     = '0;
          do_begin  = 1'b1;
          begin_cmd = item_i.app_command ? CMD_APP : item_i.cmd_index;
        end
        OP_XCHG: begin
          case (phase_q)
            PH_DESEL: begin
              sel_d     = 1'b1;
              phase_d   = PH_SELDUMMY;
              rdy_cnt_d = cfg_i.ready_timeout_ms;
              res.valid = 1'b1;
              res.tx_byte = FILL_BYTE;
            end
            PH_SELDUMMY: begin
              phase_d   = PH_WAITRDY;
              res.valid = 1'b1;
              res.tx_byte = FILL_BYTE;
            end
            PH_WAITRDY: begin
              res.valid = 1'b1;
              if (item_i.rx_byte == FILL_BYTE) begin
                phase_d     = PH_SEND;
                pos_d       = POS_ARG0;
                res.tx_byte = {START_BITS, eff_cmd};
              end else begin
                res.tx_byte = FILL_BYTE;
                if (rdy_cnt_q == '0) begin
                  sel_d   = 1'b0;
                  phase_d = PH_TODESEL;
                end
              end
            end
            PH_TODESEL: begin
              phase_d             = PH_IDLE;
              app_d               = 1'b0;
              res.valid           = 1'b1;
              res.kind            = 1'b1;
              res.response        = FILL_BYTE;
              res.ready_timed_out = 1'b1;
            end
            PH_SEND: begin
              case (pos_q)
                POS_ARG0: begin
                  pos_d = POS_ARG1;
                  res.valid = 1'b1;
                  res.tx_byte = eff_arg[31:24];
                end
                POS_ARG1: begin
                  pos_d = POS_ARG2;
                  res.valid = 1'b1;
                  res.tx_byte = eff_arg[23:16];
                end
                POS_ARG2: begin
                  pos_d = POS_ARG3;
                  res.valid = 1'b1;
                  res.tx_byte = eff_arg[15:8];
                end
                POS_ARG3: begin
                  pos_d = POS_CRC;
                  res.valid = 1'b1;
                  res.tx_byte = eff_arg[7:0];
                end
                POS_CRC: begin
                  pos_d = POS_DONE;
                  res.valid = 1'b1;
                  if (eff_cmd == CMD_GO_IDLE) begin
                    res.tx_byte = CRC_CMD0;
                  end else if (eff_cmd == CMD_SEND_IF_COND) begin
                    res.tx_byte = CRC_CMD8;
                  end else begin
                    res.tx_byte = CRC_OTHER;
                  end
                end
                default: begin
                  // CMD12 sends one stuff byte whose reply is dropped
                  if (eff_cmd == CMD_STOP) begin
                    phase_d = PH_DISCARD;
                    res.valid = 1'b1;
                    res.tx_byte = FILL_BYTE;
                  end else begin
                    do_poll = 1'b1;
                  end
                end
              endcase
            end
            PH_DISCARD: begin
              do_poll = 1'b1;
            end
            PH_RESP: begin
              poll_left = poll_cnt_q;
              if (item_i.rx_byte[ByteW-1]) begin
                if (poll_cnt_q != '0) begin
                  poll_left = poll_cnt_q - 1'b1;
                end
                poll_cnt_d = poll_left;
              end
              if (item_i.rx_byte[ByteW-1] && poll_left != '0) begin
                res.valid = 1'b1;
                res.tx_byte = FILL_BYTE;
              end else if (app_q && item_i.rx_byte <= RESP_IDLE_MAX) begin
                // CMD55 accepted: move on to the real command
                app_d     = 1'b0;
                pos_d     = '0;
                do_begin  = 1'b1;
                begin_cmd = cmd_q;
              end else begin
                phase_d      = PH_IDLE;
                app_d        = 1'b0;
                res.valid    = 1'b1;
                res.kind     = 1'b1;
                res.response = item_i.rx_byte;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (do_begin) begin
      res.valid = 1'b1;
      if (begin_cmd != CMD_STOP) begin
        sel_d       = 1'b0;
        phase_d     = PH_DESEL;
        res.tx_byte = FILL_BYTE;
      end else begin
        phase_d     = PH_SEND;
        pos_d       = POS_ARG0;
        res.tx_byte = {START_BITS, CMD_STOP};
      end
    end

    if (do_poll) begin
      poll_cnt_d  = (cfg_i.response_poll_limit == '0) ? PollW'(1)
                                                      : cfg_i.response_poll_limit;
      phase_d     = PH_RESP;
      res.valid   = 1'b1;
      res.tx_byte = FILL_BYTE;
    end

    res.chip_select_low = sel_d;
  end

  assign res_o = res;

endmodule

// ===== rtl/core/sd_spi_command_sender_top.sv =====
// SD card SPI command sender: config registers, sequencer and result register.
`timescale 1ns / 1ps

// Accepts one item per clock: a start, an SPI byte-exchange completion or a
// millisecond tick. Each item is worked by the sequencer's combinational
// next-state logic, and its result, if any (a byte to clock out or a
// finished-command report), appears in the result register the cycle after.
// The result register lets a new item in while the last result is being
// taken; input ready drops only when that register is full and the sink is
// not ready. Feed each byte the card returns back as the next exchange item.
// Configuration writes belong to idle periods.
module sd_spi_command_sender_top
  import sdspi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sdspi_cmd_if.sink           cmd_i,
  sdspi_res_if.source         res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  item_t item;
  res_t  eng_res;
  res_t  res_q;
  logic  res_valid_q;
  logic  acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready_timeout_ms    <= TIMEOUT_RST;
      cfg_q.response_poll_limit <= POLL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_READY_TIMEOUT: cfg_q.ready_timeout_ms    <= cfg_wdata_i[TimeoutW-1:0];
        CFG_POLL_LIMIT:    cfg_q.response_poll_limit <= cfg_wdata_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign acc         = cmd_i.valid && cmd_i.ready;

  assign item.operation   = cmd_i.operation;
  assign item.cmd_index   = cmd_i.cmd_index;
  assign item.app_command = cmd_i.app_command;
  assign item.argument    = cmd_i.argument;
  assign item.rx_byte     = cmd_i.rx_byte;

  sdspi_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (acc) begin
      res_valid_q <= eng_res.valid;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // payload: load only when a new beat carries a result
  always_ff @(posedge clk_i) begin
    if (acc && eng_res.valid) begin
      res_q <= eng_res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.kind            = res_q.kind;
  assign res_o.tx_byte         = res_q.tx_byte;
  assign res_o.chip_select_low = res_q.chip_select_low;
  assign res_o.response        = res_q.response;
  assign res_o.ready_timed_out = res_q.ready_timed_out;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !cmd_i.ready)
    else $error("result register would be overwritten while stalled");

  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_i.operation == OP_TICK) |=> !res_valid_q)
    else $error("tick produced a result");

  a_timeout_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_o.ready_timed_out) |->
      (res_o.kind && res_o.response == FILL_BYTE && !res_o.chip_select_low))
    else $error("timeout report malformed");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.kind) |->
      (res_o.response == '0 && !res_o.ready_timed_out))
    else $error("byte result carries report fields");

  a_finish_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_o.kind) |-> (res_o.tx_byte == '0))
    else $error("finish result carries a tx byte");
`endif

endmodule
